[sv/load_cell_adc_serial_reader_top_macros.svh]
// assertion helpers shared by the rtl
`ifndef LOAD_CELL_ADC_SERIAL_READER_TOP_MACROS_SVH
`define LOAD_CELL_ADC_SERIAL_READER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LCAR_ASSERT_NOW(label, clk, rstn, cond) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
		else $error("assertion failed: immediate condition");
`define LCAR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle condition");
`else
`define LCAR_ASSERT_NOW(label, clk, rstn, cond)
`define LCAR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[sv/lcar_pkg.sv]
`timescale 1ns / 1ps
package lcar_pkg;

	localparam int CODE_W  = 24;
	localparam int SCALE_W = 32;
	localparam int TOUT_W  = 20;
	localparam int CFG_IDX_W = 4;

	localparam logic [CODE_W-1:0] SIGN_FLIP = 24'h800000;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 4'd1;

	localparam logic [SCALE_W-1:0] SCALE_RESET   = 32'd9870992;
	localparam logic [TOUT_W-1:0]  TIMEOUT_RESET = 20'd1000000;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_WAIT  = 3'd1,
		PH_HIGH  = 3'd2,
		PH_LOW   = 3'd3,
		PH_GAIN1 = 3'd4,
		PH_GAIN2 = 3'd5
	} phase_t;

	// packed so that clock_level sits in the lowest bit
	typedef struct packed {
		logic              timed_out;
		logic [CODE_W-1:0] weight;
		logic [CODE_W-1:0] raw_code;
		logic              sample_done;
		logic              busy_res;
		logic              clock_level;
	} result_t;

	localparam int RESULT_W = $bits(result_t);
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

[sv/lcar_core.sv]
`timescale 1ns / 1ps
module lcar_core #(
	parameter int DATA_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          start_req,
	input  logic                          data_level,
	input  logic [lcar_pkg::SCALE_W-1:0]  scale_reciprocal,
	input  logic [lcar_pkg::TOUT_W-1:0]   ready_timeout,
	output lcar_pkg::result_t             result,
	output lcar_pkg::phase_t              phase
);
	import lcar_pkg::*;

	localparam int BIT_W = $clog2(DATA_BITS + 1);

	phase_t              phase_q, phase_d;
	logic [BIT_W-1:0]    bit_index_q, bit_index_d;
	logic [CODE_W-1:0]   shift_q, shift_d;
	logic [TOUT_W-1:0]   wait_count_q, wait_count_d;
	logic                low_seen_q, low_seen_d;
	logic                tout_flag_q, tout_flag_d;
	logic [CODE_W-1:0]   raw;
	logic [CODE_W+SCALE_W-1:0] product;

	assign raw     = shift_q ^ SIGN_FLIP;
	assign product = {{SCALE_W{1'b0}}, raw} * {{CODE_W{1'b0}}, scale_reciprocal};

	always_comb begin
		phase_d      = phase_q;
		bit_index_d  = bit_index_q;
		shift_d      = shift_q;
		wait_count_d = wait_count_q;
		low_seen_d   = low_seen_q;
		tout_flag_d  = tout_flag_q;
		result       = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d      = PH_WAIT;
					bit_index_d  = '0;
					shift_d      = '0;
					wait_count_d = '0;
					low_seen_d   = 1'b0;
					tout_flag_d  = 1'b0;
				end
			end
			PH_WAIT: begin
				if (!data_level && low_seen_q) begin
					phase_d = PH_HIGH;
				end else begin
					low_seen_d   = !data_level;
					wait_count_d = wait_count_q + 1'b1;
					if (wait_count_d >= ready_timeout) begin
						tout_flag_d = 1'b1;
						phase_d     = PH_HIGH;
					end
				end
			end
			PH_HIGH: begin
				phase_d = PH_LOW;
			end
			PH_LOW: begin
				shift_d     = {shift_q[CODE_W-2:0], data_level};
				bit_index_d = bit_index_q + 1'b1;
				if (bit_index_d >= BIT_W'(DATA_BITS))
					phase_d = PH_GAIN1;
				else
					phase_d = PH_HIGH;
			end
			PH_GAIN1: begin
				phase_d = PH_GAIN2;
			end
			PH_GAIN2: begin
				result.raw_code    = raw;
				result.weight      = product[CODE_W+SCALE_W-1:SCALE_W];
				result.timed_out   = tout_flag_q;
				result.sample_done = 1'b1;
				phase_d            = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		result.clock_level = (phase_d == PH_HIGH) || (phase_d == PH_GAIN1) ||
			(phase_d == PH_GAIN2);
		result.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_index_q  <= '0;
			shift_q      <= '0;
			wait_count_q <= '0;
			low_seen_q   <= 1'b0;
			tout_flag_q  <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_index_q  <= bit_index_d;
			shift_q      <= shift_d;
			wait_count_q <= wait_count_d;
			low_seen_q   <= low_seen_d;
			tout_flag_q  <= tout_flag_d;
		end
	end

	assign phase = phase_q;

endmodule

[sv/load_cell_adc_serial_reader_top.sv]
`timescale 1ns / 1ps
// readout controller for a two-wire 24-bit load-cell converter at gain 128
// slave stream: one transaction per half-clock tick, tdata = start_req, data_level
// master stream: one transaction per tick, carrying the clock line level, busy,
//   sample_done and, on the completing tick, raw_code, weight and timed_out
// config channel: cfg_index 0 writes scale_reciprocal, 1 writes ready_timeout,
//   other indexes are ignored; always ready, write only while no readout runs
// a tick accepted into the input register reaches m_axis_tdata through the
//   result register unless the result register is still held by a stalled
//   receiver
// throughput: one tick per cycle unless stalled; single input and result stage
// a full readout spans 2 * DATA_BITS + 3 ticks plus the data-ready wait
// weight is a 24 x 32 multiply feeding the result register directly
// reset: readout idle, both stages empty, registers at their reset values
// when m_axis_tready is low the result register holds; the input register
//   still fills once, then s_axis_tready drops until the result is taken
`include "load_cell_adc_serial_reader_top_macros.svh"
module load_cell_adc_serial_reader_top #(
	parameter int DATA_BITS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // start_req, data_level
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// clock_level, busy_res, sample_done, raw_code, weight, timed_out
	output logic [lcar_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lcar_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lcar_pkg::SCALE_W-1:0]       cfg_data
);
	import lcar_pkg::*;

	logic                 in_valid_s1;
	logic                 start_s1;
	logic                 data_s1;
	logic                 out_valid_q;
	result_t              out_q;
	result_t              core_res;
	phase_t               phase;
	logic                 advance;
	logic [SCALE_W-1:0]   scale_q;
	logic [TOUT_W-1:0]    timeout_q;

	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCALE:   scale_q   <= cfg_data;
				REG_TIMEOUT: timeout_q <= cfg_data[TOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			start_s1 <= s_axis_tdata[0];
			data_s1  <= s_axis_tdata[1];
		end
	end

	lcar_core #(
		.DATA_BITS(DATA_BITS)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.start_req        (start_s1),
		.data_level       (data_s1),
		.scale_reciprocal (scale_q),
		.ready_timeout    (timeout_q),
		.result           (core_res),
		.phase            (phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_q};

	`LCAR_ASSERT_NOW(a_done_ends_busy, clk, arst_n,
		!(out_valid_q && out_q.sample_done && out_q.busy_res))
	`LCAR_ASSERT_NOW(a_clock_only_busy, clk, arst_n,
		!(out_valid_q && out_q.clock_level && !out_q.busy_res))
	`LCAR_ASSERT_NOW(a_code_only_on_done, clk, arst_n,
		!(out_valid_q && !out_q.sample_done && (out_q.raw_code != '0)))
	`LCAR_ASSERT_NEXT(a_gain2_returns_idle, clk, arst_n,
		advance && (phase == PH_GAIN2), phase == PH_IDLE)

endmodule
